>>> hdl/fmmd_pkg.sv
// Shared types and constants for the frame mean motion detector.
`default_nettype none

package fmmd_pkg;

    // Field and state widths
    localparam int PIX_W   = 8;
    localparam int MEAN_W  = 16;
    localparam int SUM_W   = 30;
    localparam int CNT_W   = 23;
    localparam int TICK_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Frame size bound
    localparam int MAX_FRAME_PIXELS = 4194304;

    // Gray conversion: weights scaled by 2^14, rounded
    localparam int GRAY_ACC_W = 22;
    localparam int GRAY_SHIFT = 14;
    localparam int W_BLUE     = 1868;
    localparam int W_GREEN    = 9617;
    localparam int W_RED      = 4899;
    localparam int GRAY_ROUND = 8192;

    // Mean divider: quotient always fits 16 bits since gray <= 255
    localparam int DIVIDEND_W = SUM_W + 8;
    localparam int QUO_W      = MEAN_W;
    localparam int REM_W      = CNT_W;
    localparam int STEP_W     = 4;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd2560;
    localparam logic [CFG_W-1:0] COOLDOWN_RESET  = 16'd60;
    localparam logic [TICK_W-1:0] TICKS_SAT      = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 1'd1;

    // Item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             end_of_frame;
    } item_t;

    typedef struct packed {
        logic [MEAN_W-1:0] frame_mean;
        logic [MEAN_W-1:0] mean_change;
        logic              motion;
        logic              frame_overflow;
    } result_t;

    // One closed frame waiting for its mean
    typedef struct packed {
        logic [SUM_W-1:0] gray_sum;
        logic [CNT_W-1:0] pixel_count;
        logic             overflow;
    } frame_t;

    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] cooldown_ticks;
    } cfg_t;

    // Queue status seen by the front part
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

>>> hdl/fmmd_front.sv
// Front part: gray conversion, frame accumulation and tick admission.
`default_nettype none

module fmmd_front
    import fmmd_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         item_valid,
    output logic        item_stall,
    input  wire item_t  item,
    input  wire         backlog,
    input  wire q_stat_t q_stat,
    output logic        q_push,
    output frame_t      q_data,
    output logic        tick_inc
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]      s1_gray_reg;
    logic                  s1_eof_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  ovf_reg, ovf_next;

    logic [GRAY_ACC_W-1:0] gray_acc;
    logic                  eof_pending;
    logic                  pending;
    logic                  s1_blocked;
    logic                  s1_fire;
    logic                  pix_take;
    logic                  has_room;
    logic [SUM_W-1:0]      frame_sum;
    logic [CNT_W-1:0]      frame_cnt;
    logic                  frame_ovf;

    // Weighted gray level, rounded to nearest
    assign gray_acc = GRAY_ACC_W'(W_BLUE)  * GRAY_ACC_W'(item.blue)
                    + GRAY_ACC_W'(W_GREEN) * GRAY_ACC_W'(item.green)
                    + GRAY_ACC_W'(W_RED)   * GRAY_ACC_W'(item.red)
                    + GRAY_ACC_W'(GRAY_ROUND);

    // Hold ticks while any closed frame has not had its motion decision
    assign eof_pending = s1_valid_reg && s1_eof_reg;
    assign pending     = backlog || eof_pending;
    assign s1_blocked  = eof_pending && q_stat.full;
    assign s1_fire     = s1_valid_reg && !s1_blocked;

    assign item_stall = (item.mode == MODE_TICK) ? pending : s1_blocked;
    assign pix_take   = item_valid && (item.mode == MODE_PIXEL) && !s1_blocked;
    assign tick_inc   = item_valid && (item.mode == MODE_TICK) && !pending;

    assign s1_valid_next = s1_blocked ? s1_valid_reg : pix_take;

    // Stage 1: registered gray level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            s1_gray_reg <= gray_acc[GRAY_SHIFT +: PIX_W];
            s1_eof_reg  <= item.end_of_frame;
        end
    end

    // Accumulate, close the frame on its last pixel
    assign has_room  = cnt_reg < CNT_W'(MAX_FRAME_PIXELS);
    assign frame_sum = has_room ? sum_reg + SUM_W'(s1_gray_reg) : sum_reg;
    assign frame_cnt = has_room ? cnt_reg + CNT_W'(1) : cnt_reg;
    assign frame_ovf = ovf_reg || !has_room;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        q_push   = 1'b0;
        q_data   = '{gray_sum: frame_sum, pixel_count: frame_cnt, overflow: frame_ovf};
        if (s1_fire)
        begin
            if (s1_eof_reg)
            begin
                q_push   = 1'b1;
                sum_next = '0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                sum_next = frame_sum;
                cnt_next = frame_cnt;
                ovf_next = frame_ovf;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/fmmd_queue.sv
// Two-entry queue of closed frames between the front and back parts.
`default_nettype none

module fmmd_queue
    import fmmd_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          push,
    input  wire frame_t  push_data,
    input  wire          pop,
    output frame_t       head,
    output q_stat_t      stat
);

    frame_t      entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = count_reg == 2'd2;
    assign stat.empty = count_reg == 2'd0;

    assign wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
    assign rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Store pushed frame
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !stat.full || pop)
        else $error("frame pushed into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !stat.empty)
        else $error("frame popped from empty queue");
`endif

endmodule

`default_nettype wire

>>> hdl/fmmd_back.sv
// Back part: serial mean divider, motion decision, tick count and result register.
`default_nettype none

module fmmd_back
    import fmmd_pkg::*;
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire q_stat_t q_stat,
    input  wire frame_t  q_head,
    output logic         q_pop,
    output logic         busy,
    input  wire          tick_inc,
    input  wire cfg_t    cfg,
    output logic         result_valid,
    input  wire          result_stall,
    output result_t      result
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    dq_reg, dq_next;
    logic [CNT_W-1:0]    div_reg, div_next;
    logic                ovf_reg, ovf_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [MEAN_W-1:0]   prev_reg, prev_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [DIVIDEND_W-1:0] dividend;
    logic [REM_W:0]        shifted;
    logic [REM_W:0]        diff;
    logic                  ge;
    logic [MEAN_W-1:0]     change;
    logic                  motion;
    logic                  out_free;
    logic                  fin_fire;

    // Dividend with half the count added for rounding
    assign dividend = {q_head.gray_sum, 8'b0}
                    + DIVIDEND_W'(q_head.pixel_count[CNT_W-1:1]);

    // One restoring step per cycle
    assign shifted = {rem_reg, dq_reg[QUO_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign ge      = shifted >= {1'b0, div_reg};

    // Decision on the finished quotient
    assign change   = (dq_reg >= prev_reg) ? dq_reg - prev_reg : prev_reg - dq_reg;
    assign motion   = (ticks_reg > cfg.cooldown_ticks) && (change > cfg.threshold);
    assign out_free = !out_valid_reg || !result_stall;
    assign fin_fire = (state_reg == ST_FIN) && out_free;

    assign busy         = state_reg != ST_IDLE;
    assign q_pop        = (state_reg == ST_IDLE) && !q_stat.empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        div_next       = div_reg;
        ovf_next       = ovf_reg;
        step_next      = step_reg;
        prev_next      = prev_reg;
        ticks_next     = ticks_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;

        // Count ticks, saturating
        if (tick_inc && ticks_reg != TICKS_SAT)
        begin
            ticks_next = ticks_reg + TICK_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    rem_next   = REM_W'(dividend[DIVIDEND_W-1:QUO_W]);
                    dq_next    = dividend[QUO_W-1:0];
                    div_next   = q_head.pixel_count;
                    ovf_next   = q_head.overflow;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
                dq_next   = {dq_reg[QUO_W-2:0], ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next       = '{frame_mean: dq_reg, mean_change: change,
                                       motion: motion, frame_overflow: ovf_reg};
                    out_valid_next = 1'b1;
                    prev_next      = dq_reg;
                    if (motion)
                    begin
                        ticks_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            ticks_reg     <= TICKS_SAT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        div_reg  <= div_next;
        ovf_reg  <= ovf_next;
        step_reg <= step_next;
        out_reg  <= out_next;
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");

    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && step_reg == STEP_W'(QUO_W - 1)) |=> state_reg == ST_FIN)
        else $error("divider did not finish after all quotient bits");

    a_tick_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        tick_inc |-> state_reg == ST_IDLE && q_stat.empty)
        else $error("tick taken while a frame decision is pending");

    a_fin_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_fire |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("finished frame did not reach the result register");
`endif

endmodule

`default_nettype wire

>>> hdl/frame_mean_motion_detector.sv
// Top level of the frame mean motion detector: configuration registers and part wiring.
// Usage:
//   item channel (item_valid/item_stall/item): pixels (mode 0) and time ticks (mode 1).
//   result channel (result_valid/result_stall/result): one transaction per frame,
//   issued for the end_of_frame pixel, carrying mean, change, motion and overflow.
//   cfg_we/cfg_index/cfg_data write threshold (0) and cooldown_ticks (1), when idle.
// Throughput: one pixel per cycle, unless a closed frame waits on a full queue. The
// frame mean comes from a one-bit-per-cycle divider: after the edge that accepts a
// frame's last pixel, its result passes one gray stage, the queue, 16 divider steps
// and a decision step that loads the result register. The back part takes one frame
// at a time; pixels of the next frame keep flowing and up to two closed frames queue.
// A tick is held (item_stall high) while any closed frame still awaits its motion
// decision, since that decision may restart the tick count.
// When the receiver stalls, the result register holds its transaction; the back
// part then waits in its decision step, and the queue and then the pixel
// input fill and stall in turn.
// Reset clears the accumulators, the previous mean, and the queue, sets the tick
// count to its saturated value and loads the register defaults (2560 and 60).
`default_nettype none

module frame_mean_motion_detector
    import fmmd_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_stall,
    input  wire item_t           item,
    output logic                 result_valid,
    input  wire                  result_stall,
    output result_t              result,
    input  wire                  cfg_we,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_W-1:0]      cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    frame_t  q_push_data;
    frame_t  q_head;
    logic    q_push;
    logic    q_pop;
    logic    back_busy;
    logic    backlog;
    logic    tick_inc;

    // Register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD: cfg_next.threshold      = cfg_data;
                REG_COOLDOWN:  cfg_next.cooldown_ticks = cfg_data;
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{threshold: THRESHOLD_RESET, cooldown_ticks: COOLDOWN_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Frames queued or in the back part
    assign backlog = !q_stat.empty || back_busy;

    fmmd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .backlog    (backlog),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_data     (q_push_data),
        .tick_inc   (tick_inc)
    );

    fmmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    fmmd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .busy         (back_busy),
        .tick_inc     (tick_inc),
        .cfg          (cfg_reg),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> bench/tb_frame_mean_motion_detector.sv
// Self-checking testbench for the frame mean motion detector, with its own frame-mean predictor.
`default_nettype none

module tb_frame_mean_motion_detector
    import fmmd_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD        = 10;
    localparam int SETTLE_CYCLES     = 40;
    localparam int QUIET_LIMIT       = 4000;
    localparam int ITEMS_PER_SESSION = 185;
    localparam int NUM_SESSIONS      = 6;

    // Gray weights scaled by 2^14 and the frame size bound
    localparam int unsigned WEIGHT_B    = 1868;
    localparam int unsigned WEIGHT_G    = 9617;
    localparam int unsigned WEIGHT_R    = 4899;
    localparam int unsigned GRAY_BIAS   = 8192;
    localparam int unsigned GRAY_BITS   = 14;
    localparam int unsigned PIXEL_BOUND = 4194304;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 item_valid = 1'b0;
    logic                 item_stall;
    item_t                item = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_THRESHOLD;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Predictor state and its copy of the registers
    logic [SUM_W-1:0]  acc_gray;
    logic [CNT_W-1:0]  acc_pixels;
    logic [MEAN_W-1:0] prev_frame_mean;
    logic [TICK_W-1:0] tick_count;
    logic              overflow_flag;
    logic [CFG_W-1:0]  cfg_threshold;
    logic [CFG_W-1:0]  cfg_cooldown;

    result_t pending_frames[$];
    row_t    directed_rows[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit calm = 1'b0;
    int mismatches = 0;
    int items_sent = 0;
    int frames_seen = 0;
    int motions_seen = 0;
    int quiet_cycles = 0;

    frame_mean_motion_detector dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the predictor by one item; return 1 when the item closes a frame.
    // Frames past the pixel bound would be over four million pixels long, so
    // the stimulus keeps frames short and the bound branch stays idle.
    function automatic bit track_item(input item_t it, output result_t res);
        int unsigned       weighted;
        logic [7:0]        gray;
        logic [37:0]       scaled;
        logic [37:0]       quo;
        logic [MEAN_W-1:0] mean;
        logic [MEAN_W-1:0] change;
        res = '0;
        if (it.mode == MODE_TICK)
        begin
            if (tick_count != {TICK_W{1'b1}})
                tick_count = tick_count + 1'b1;
            return 1'b0;
        end
        weighted = WEIGHT_B * it.blue + WEIGHT_G * it.green + WEIGHT_R * it.red + GRAY_BIAS;
        gray = 8'(weighted >> GRAY_BITS);
        if (acc_pixels < PIXEL_BOUND)
        begin
            acc_gray = acc_gray + gray;
            acc_pixels = acc_pixels + 1'b1;
        end
        else
        begin
            overflow_flag = 1'b1;
        end
        if (!it.end_of_frame)
            return 1'b0;

        // Close the frame: rounded mean, change and motion decision
        scaled = {acc_gray, 8'd0} + (acc_pixels >> 1);
        quo = scaled / acc_pixels;
        mean = (quo > 38'hFFFF) ? 16'hFFFF : quo[MEAN_W-1:0];
        change = (mean >= prev_frame_mean) ? mean - prev_frame_mean : prev_frame_mean - mean;
        res.frame_mean = mean;
        res.mean_change = change;
        res.motion = (tick_count > cfg_cooldown) && (change > cfg_threshold);
        res.frame_overflow = overflow_flag;
        if (res.motion)
            tick_count = '0;
        prev_frame_mean = mean;
        acc_gray = '0;
        acc_pixels = '0;
        overflow_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic add_row(input logic mode, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r, input logic eof, input bit typed,
                           input logic [15:0] mean, input logic [15:0] change,
                           input logic motion);
        row_t row;
        row.it = '{mode: mode, blue: b, green: g, red: r, end_of_frame: eof};
        row.typed = typed;
        row.want = '{frame_mean: mean, mean_change: change, motion: motion,
                     frame_overflow: 1'b0};
        directed_rows.push_back(row);
    endtask

    // Offer one item, hold it until accepted, then record what it should produce
    task automatic send_item(input item_t it, input bit typed, input result_t typed_res);
        result_t res;
        bit      closes;
        while (!calm && ($urandom_range(99) < send_idle_pct))
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall !== 1'b0);
        items_sent++;
        closes = track_item(it, res);
        if (closes)
            pending_frames.push_back(typed ? typed_res : res);
    endtask

    // Wait for every expected frame, then let the pipeline empty
    task automatic settle();
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers on back-to-back edges
    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] cd);
        cfg_we <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data <= thr;
        @(posedge clk);
        cfg_index <= REG_COOLDOWN;
        cfg_data <= cd;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_threshold = thr;
        cfg_cooldown = cd;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Check each result transaction against the oldest expectation; draw new stalls
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            frames_seen++;
            if (result.motion)
                motions_seen++;
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = pending_frames.pop_front();
                compare_field("frame_mean", want.frame_mean, result.frame_mean);
                compare_field("mean_change", want.mean_change, result.mean_change);
                compare_field("motion", want.motion, result.motion);
                compare_field("frame_overflow", want.frame_overflow, result.frame_overflow);
            end
        end
        result_stall <= !calm && ($urandom_range(99) < stall_pct);
    end

    // Stop the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, %0d frames still expected", $time, pending_frames.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          send_modes[4];
        int          stall_modes[4];
        logic [15:0] thr_set[NUM_SESSIONS];
        logic [15:0] cd_set[NUM_SESSIONS];
        result_t     none;
        item_t       it;
        int          session;
        int          session_items;
        int          len;
        int          run;
        int          pick;
        bit          wild;
        logic [7:0]  base_b;
        logic [7:0]  base_g;
        logic [7:0]  base_r;

        send_modes = '{0, 49, 0, 38};
        stall_modes = '{0, 0, 49, 38};
        thr_set = '{16'd2560, 16'd0, 16'hFFFF, 16'd768, 16'd0, 16'd1280};
        cd_set = '{16'd60, 16'd0, 16'hFFFF, 16'd4, 16'd0, 16'd1};
        thr_set[4] = 16'($urandom_range(4000));
        cd_set[4] = 16'($urandom_range(10));
        none = '0;

        acc_gray = '0;
        acc_pixels = '0;
        prev_frame_mean = '0;
        tick_count = {TICK_W{1'b1}};
        overflow_flag = 1'b0;
        cfg_threshold = THRESHOLD_RESET;
        cfg_cooldown = COOLDOWN_RESET;

        // Directed rows, starting from reset defaults and a saturated tick count
        // tick with its end mark set: ignored, count stays saturated
        add_row(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        // black frame: no change
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000, 16'h0000, 1'b0);
        // white frame: full-scale jump, cooldown long expired
        add_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 16'hFF00, 16'hFF00, 1'b1);
        // back to black: large change held off by the restarted tick count
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 16'h0000, 16'hFF00, 1'b0);
        // one primary at a time
        add_row(MODE_PIXEL, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'hFF, 8'h00, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        // multi-pixel frame with a tick in the middle
        add_row(MODE_PIXEL, 8'd10, 8'd20, 8'd30, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_TICK, 8'h5A, 8'hA5, 8'h3C, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'd200, 8'd100, 8'd50, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        // mean rounding over two and three pixels
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'h01, 8'h00, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 16'h0, 16'h0, 1'b0);
        add_row(MODE_PIXEL, 8'h00, 8'h01, 8'h00, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);
        // white again: big change, still inside the cooldown
        add_row(MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 16'h0, 16'h0, 1'b0);

        // Hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
        item_valid <= 1'b0;
        settle();

        // Random sessions: new register settings each time, idling patterns in rotation
        for (session = 0; session < NUM_SESSIONS; session++)
        begin
            set_config(thr_set[session], cd_set[session]);
            send_idle_pct = send_modes[session % 4];
            stall_pct = stall_modes[session % 4];
            session_items = 0;
            while (session_items < ITEMS_PER_SESSION)
            begin
                calm = ($urandom_range(3) == 0);
                pick = $urandom_range(99);
                if (pick < 75)
                    len = $urandom_range(1, 8);
                else if (pick < 95)
                    len = $urandom_range(9, 40);
                else
                    len = $urandom_range(60, 150);
                // keep the session within its item budget
                if (len > ITEMS_PER_SESSION - session_items)
                    len = ITEMS_PER_SESSION - session_items;
                base_b = 8'($urandom_range(255));
                base_g = 8'($urandom_range(255));
                base_r = 8'($urandom_range(255));
                wild = ($urandom_range(2) == 0);
                for (int p = 0; p < len; p++)
                begin
                    // drop in ticks: mostly short bursts, sometimes a long run
                    pick = $urandom_range(99);
                    run = (pick < 12) ? $urandom_range(1, 3) :
                          (pick < 15) ? $urandom_range(20, 90) : 0;
                    if (session_items + run + len - p > ITEMS_PER_SESSION)
                        run = 0;
                    repeat (run)
                    begin
                        it = '{mode: MODE_TICK, blue: 8'($urandom_range(255)),
                               green: 8'($urandom_range(255)), red: 8'($urandom_range(255)),
                               end_of_frame: 1'($urandom_range(1))};
                        send_item(it, 1'b0, none);
                        session_items++;
                    end
                    it.mode = MODE_PIXEL;
                    it.blue = wild ? 8'($urandom_range(255)) : base_b ^ 8'($urandom_range(15));
                    it.green = wild ? 8'($urandom_range(255)) : base_g ^ 8'($urandom_range(15));
                    it.red = wild ? 8'($urandom_range(255)) : base_r ^ 8'($urandom_range(15));
                    it.end_of_frame = (p == len - 1);
                    send_item(it, 1'b0, none);
                    session_items++;
                end
            end
            calm = 1'b0;
            item_valid <= 1'b0;
            settle();
        end

        $display("Covered %0d item transactions and %0d frame results (%0d with motion)",
                 items_sent, frames_seen, motions_seen);
        $display("over %0d register settings and four idling patterns; %0d mismatches",
                 NUM_SESSIONS, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/fmmd_pkg.sv
hdl/fmmd_front.sv
hdl/fmmd_queue.sv
hdl/fmmd_back.sv
hdl/frame_mean_motion_detector.sv
bench/tb_frame_mean_motion_detector.sv
